>>> rtl/core/mlhp_pkg.sv
// Package for the long header parser: constants, the queue command type and
// the result kind codes. No dependencies.
`default_nettype none
package mlhp_pkg;

  localparam int unsigned POS_W = 4;

  localparam logic [POS_W-1:0] WIRED_HDR_POS    = 4'd11;
  localparam logic [POS_W-1:0] HEADER_LEN       = 4'd12;
  localparam logic [POS_W-1:0] WIRELESS_HDR_POS = 4'd14;
  localparam logic [POS_W-1:0] POS_MAX          = 4'd15;

  localparam logic [7:0] MODE_MASK = 8'h1F;
  localparam logic [7:0] NIBBLE_HI = 8'hF0;
  localparam logic [7:0] FILL_BYTE = 8'h2F;

  // Crypt modes. The first three carry the block counter in the upper nibble
  // of the first config byte; the asymmetric mode uses the whole byte.
  localparam logic [4:0] MODE_PLAIN   = 5'd0;
  localparam logic [4:0] MODE_CBC     = 5'd5;
  localparam logic [4:0] MODE_CBC_EPH = 5'd7;
  localparam logic [4:0] MODE_ASYM    = 5'd13;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Work orders handed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_ERROR    = 3'd0,  // short frame
    OP_PAYLOAD  = 3'd1,  // one payload byte
    OP_HDR      = 3'd2,  // wired header only
    OP_HDR_BYTE = 3'd3,  // header, then the current byte (fill bytes dropped)
    OP_HDR_HELD = 3'd4   // header, both held bytes, then the current byte
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] meter_id;
    logic [7:0]  access_number;
    logic [7:0]  meter_status;
    logic [4:0]  crypt_mode;
    logic [7:0]  block_count;
    logic [7:0]  held0;
    logic [7:0]  held1;
    logic [7:0]  data_byte;
    logic        frame_end;
  } cmd_t;

  // Handshake between a queue user and the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> rtl/core/mlhp_in_if.sv
// Input channel of the long header parser: one frame byte per transfer.
// No dependencies.
`default_nettype none
interface mlhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source (output valid, output in_byte, output frame_end, input ready);
  modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mlhp_out_if.sv
// Result channel of the long header parser: one result item per transfer.
// No dependencies.
`default_nettype none
interface mlhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] meter_id;
  logic [7:0]  access_number;
  logic [7:0]  meter_status;
  logic [4:0]  crypt_mode;
  logic [7:0]  block_count;
  logic [7:0]  out_byte;
  logic        last;

  modport source (output valid, output kind, output meter_id, output access_number,
                  output meter_status, output crypt_mode, output block_count,
                  output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input meter_id, input access_number,
                  input meter_status, input crypt_mode, input block_count,
                  input out_byte, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mbus_long_header_parser_unit.sv
// Top level of the M-Bus long header parser.
// Depends on mlhp_pkg, mlhp_in_if, mlhp_out_if, mlhp_front, mlhp_queue and mlhp_back.
// Usage: frame bytes arrive on the frame channel, one byte per transfer, with
// frame_end set on the final byte. Results leave on the result channel: one
// header result per long enough frame, then the payload bytes, or one short
// frame error when the frame ends too early. The last flag marks the final
// result that a frame causes.
// The configuration port writes wired_format whenever cfg_we is high; the
// write also drops the frame in progress. Write it only while the block is idle.
// Throughput: the front part takes one byte per cycle as long as the command
// queue has room. The back part delivers one result per cycle from its output
// register while the receiver takes them. Most bytes yield one result, but the byte
// that carries a wireless header yields up to four results, and the queue of
// QUEUE_DEPTH commands absorbs that burst.
// Each command is registered in the queue, and its results in the output register.
// When the receiver stalls, the output register holds its result, the queue
// fills, and ready on the frame channel falls once the queue is full.
// Reset clears the byte position, wired_format, the queue pointers and count and
// the output valid flag; no clearing pass is needed.
`default_nettype none
module mbus_long_header_parser_unit
  import mlhp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  mlhp_in_if.sink    frame,
  mlhp_out_if.source result
);

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head_cmd;
  q_status_t q_status;

  // Front part: classifies each byte and captures the header.
  mlhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .in_byte   (frame.in_byte),
    .frame_end (frame.frame_end),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Commands wait here so that each side can stall on its own.
  mlhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // Back part: turns commands into result transfers.
  mlhp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_cmd (head_cmd),
    .q_status (q_status),
    .pop      (pop),
    .result   (result)
  );

endmodule
`default_nettype wire

>>> rtl/core/mlhp_front.sv
// Front part: tracks the byte position, captures header and held bytes and
// turns each accepted byte into a queue command. Depends on mlhp_pkg.
`default_nettype none
module mlhp_front
  import mlhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        frame_end,
  input  wire q_status_t   q_status,
  output logic             push,
  output cmd_t             push_cmd
);

  logic             wired_format;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       header_bytes [12];
  logic [7:0]       held_payload [2];
  logic             accept;
  logic [4:0]       mode;
  logic [7:0]       blk;
  logic             fill_pair;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (frame_end) begin
      byte_position_next = '0;
    end else if (byte_position < POS_MAX) begin
      byte_position_next = byte_position + 4'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wired_format  <= 1'b0;
      byte_position <= '0;
    end else if (cfg_we) begin
      // A write aborts the frame in progress.
      wired_format  <= cfg_wdata;
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_position < HEADER_LEN) begin
      header_bytes[byte_position] <= in_byte;
    end
    if (accept && !wired_format && byte_position >= HEADER_LEN &&
        byte_position < WIRELESS_HDR_POS) begin
      held_payload[byte_position[0]] <= in_byte;
    end
  end

  // Wireless config bytes: mode from byte 11, block counter from byte 10.
  always_comb begin
    mode = 5'(header_bytes[11] & MODE_MASK);
    blk  = '0;
    if (mode inside {MODE_PLAIN, MODE_CBC, MODE_CBC_EPH}) begin
      blk = (header_bytes[10] & NIBBLE_HI) >> 4;
    end else if (mode == MODE_ASYM) begin
      blk = header_bytes[10];
    end
  end

  assign fill_pair = (held_payload[0] == FILL_BYTE) && (held_payload[1] == FILL_BYTE);

  always_comb begin
    push_cmd.op            = OP_PAYLOAD;
    push_cmd.meter_id      = {header_bytes[4], header_bytes[5], header_bytes[0],
                              header_bytes[1], header_bytes[2], header_bytes[3],
                              header_bytes[6], header_bytes[7]};
    push_cmd.access_number = header_bytes[8];
    push_cmd.meter_status  = header_bytes[9];
    push_cmd.crypt_mode    = wired_format ? 5'd0 : mode;
    push_cmd.block_count   = wired_format ? 8'd0 : blk;
    push_cmd.held0         = held_payload[0];
    push_cmd.held1         = held_payload[1];
    push_cmd.data_byte     = in_byte;
    push_cmd.frame_end     = frame_end;
    push                   = 1'b0;
    if (wired_format) begin
      if (byte_position < WIRED_HDR_POS) begin
        push_cmd.op = OP_ERROR;
        push        = accept && frame_end;
      end else if (byte_position == WIRED_HDR_POS) begin
        push_cmd.op = OP_HDR;
        push        = accept;
      end else begin
        push_cmd.op = OP_PAYLOAD;
        push        = accept;
      end
    end else begin
      if (byte_position < WIRELESS_HDR_POS) begin
        push_cmd.op = OP_ERROR;
        push        = accept && frame_end;
      end else if (byte_position == WIRELESS_HDR_POS) begin
        push_cmd.op = fill_pair ? OP_HDR_BYTE : OP_HDR_HELD;
        push        = accept;
      end else begin
        push_cmd.op = OP_PAYLOAD;
        push        = accept;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mlhp_queue.sv
// Command queue between the front and back parts of the parser.
// Depends on mlhp_pkg.
`default_nettype none
module mlhp_queue
  import mlhp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head_cmd,
  output q_status_t  status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/mlhp_back.sv
// Back part: expands each queue command into one to four result items and
// holds them in the output register. Depends on mlhp_pkg.
`default_nettype none
module mlhp_back
  import mlhp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cmd_t   head_cmd,
  input  wire q_status_t q_status,
  output logic        pop,
  mlhp_out_if.source  result
);

  logic [1:0]  step;
  logic        load;
  logic        final_step;
  logic [1:0]  r_kind;
  logic        r_header;
  logic [7:0]  r_byte;
  logic        r_last;

  assign load = !q_status.empty && (!result.valid || result.ready);
  assign pop  = load && final_step;

  // Step 0 of a header command is the header itself; later steps are bytes.
  always_comb begin
    r_kind     = KIND_PAYLOAD;
    r_header   = 1'b0;
    r_byte     = head_cmd.data_byte;
    r_last     = head_cmd.frame_end;
    final_step = 1'b1;
    case (head_cmd.op)
      OP_ERROR: begin
        r_kind = KIND_ERROR;
        r_byte = '0;
        r_last = 1'b1;
      end
      OP_PAYLOAD: begin
        r_kind = KIND_PAYLOAD;
      end
      OP_HDR: begin
        r_kind   = KIND_HEADER;
        r_header = 1'b1;
        r_byte   = '0;
      end
      OP_HDR_BYTE: begin
        if (step == 2'd0) begin
          r_kind     = KIND_HEADER;
          r_header   = 1'b1;
          r_byte     = '0;
          r_last     = 1'b0;
          final_step = 1'b0;
        end
      end
      OP_HDR_HELD: begin
        case (step)
          2'd0: begin
            r_kind     = KIND_HEADER;
            r_header   = 1'b1;
            r_byte     = '0;
            r_last     = 1'b0;
            final_step = 1'b0;
          end
          2'd1: begin
            r_byte     = head_cmd.held0;
            r_last     = 1'b0;
            final_step = 1'b0;
          end
          2'd2: begin
            r_byte     = head_cmd.held1;
            r_last     = 1'b0;
            final_step = 1'b0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        r_kind = KIND_ERROR;
        r_byte = '0;
        r_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        step         <= final_step ? 2'd0 : step + 2'd1;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.kind          <= r_kind;
      result.meter_id      <= r_header ? head_cmd.meter_id : 64'd0;
      result.access_number <= r_header ? head_cmd.access_number : 8'd0;
      result.meter_status  <= r_header ? head_cmd.meter_status : 8'd0;
      result.crypt_mode    <= r_header ? head_cmd.crypt_mode : 5'd0;
      result.block_count   <= r_header ? head_cmd.block_count : 8'd0;
      result.out_byte      <= r_byte;
      result.last          <= r_last;
    end
  end

endmodule
`default_nettype wire

>>> verif/mbus_long_header_parser_unit_test.sv
// Self-checking testbench for mbus_long_header_parser_unit: random frames in
// both header formats against a scoreboard that parses the same bytes.
// Depends on mlhp_pkg, mlhp_in_if, mlhp_out_if and the parser RTL.
`timescale 1ns / 100ps

module mbus_long_header_parser_unit_test
  import mlhp_pkg::*;
();

  localparam int RANDOM_BYTES = 390;
  // Wait after the last expected result before a register write, so that a byte
  // that causes no result has settled in the block.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 60;

  // One result as it appears on the result channel.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] meter_id;
    logic [7:0]  access_number;
    logic [7:0]  meter_status;
    logic [4:0]  crypt_mode;
    logic [7:0]  block_count;
    logic [7:0]  out_byte;
    logic        last;
  } meter_result_t;

  // The scoreboard parses every accepted frame byte with its own copy of the
  // parser state and queues the results that byte must cause. Each delivered
  // result is then matched against the oldest queued one.
  class long_header_scoreboard;
    bit              wired_mode;
    logic [3:0]      frame_pos;
    logic [7:0]      hdr [12];
    logic [7:0]      held [2];
    meter_result_t   results_due [$];
    int              errors;

    function new();
      wired_mode = 1'b0;
      frame_pos  = '0;
      errors     = 0;
    endfunction

    // A write of the format register also drops the frame in progress.
    function void set_format(bit wired);
      wired_mode = wired;
      frame_pos  = '0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void queue_payload(logic [7:0] b, logic e);
      meter_result_t r;
      r          = '0;
      r.kind     = KIND_PAYLOAD;
      r.out_byte = b;
      r.last     = e;
      results_due.push_back(r);
    endfunction

    function void queue_header(logic e);
      meter_result_t r;
      logic [4:0]    mode;
      r = '0;
      r.kind = KIND_HEADER;
      // Manufacturer first, then the serial number, version and device type.
      r.meter_id = {hdr[4], hdr[5], hdr[0], hdr[1], hdr[2], hdr[3], hdr[6], hdr[7]};
      r.access_number = hdr[8];
      r.meter_status  = hdr[9];
      if (!wired_mode) begin
        mode = 5'(hdr[11] & MODE_MASK);
        r.crypt_mode = mode;
        if (mode == MODE_PLAIN || mode == MODE_CBC || mode == MODE_CBC_EPH) begin
          r.block_count = (hdr[10] & NIBBLE_HI) >> 4;
        end else if (mode == MODE_ASYM) begin
          r.block_count = hdr[10];
        end
      end
      r.last = e;
      results_due.push_back(r);
    endfunction

    function void queue_short_frame();
      meter_result_t r;
      r      = '0;
      r.kind = KIND_ERROR;
      r.last = 1'b1;
      results_due.push_back(r);
    endfunction

    // Accepted frame byte: update the parser state and queue its results.
    function void take_byte(logic [7:0] b, logic e);
      logic [3:0] p;
      p = frame_pos;
      if (p < HEADER_LEN) hdr[p] = b;
      if (wired_mode) begin
        if (p < WIRED_HDR_POS) begin
          if (e) queue_short_frame();
        end else if (p == WIRED_HDR_POS) begin
          queue_header(e);
        end else begin
          queue_payload(b, e);
        end
      end else begin
        if (p >= HEADER_LEN && p < WIRELESS_HDR_POS) held[p[0]] = b;
        if (p < WIRELESS_HDR_POS) begin
          if (e) queue_short_frame();
        end else if (p == WIRELESS_HDR_POS) begin
          queue_header(1'b0);
          // Two leading fill bytes are dropped, anything else is passed on.
          if (!(held[0] == FILL_BYTE && held[1] == FILL_BYTE)) begin
            queue_payload(held[0], 1'b0);
            queue_payload(held[1], 1'b0);
          end
          queue_payload(b, e);
        end else begin
          queue_payload(b, e);
        end
      end
      if (e) frame_pos = '0;
      else if (p < POS_MAX) frame_pos = p + 4'd1;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(meter_result_t got);
      meter_result_t want;
      if (results_due.size() == 0) begin
        $error("result with nothing expected: kind %0d, out_byte %0h", got.kind, got.out_byte);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("meter_id", want.meter_id, got.meter_id);
      compare_field("access_number", want.access_number, got.access_number);
      compare_field("meter_status", want.meter_status, got.meter_status);
      compare_field("crypt_mode", want.crypt_mode, got.crypt_mode);
      compare_field("block_count", want.block_count, got.block_count);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  mlhp_in_if  frame_if ();
  mlhp_out_if result_if ();

  mbus_long_header_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .frame    (frame_if),
    .result   (result_if)
  );

  long_header_scoreboard book;
  int  bytes_sent;
  // When steady_in is set the sender offers bytes back to back for a frame.
  bit  steady_in;
  // The sender raises this to ask the receiver for one long hold-off.
  bit  hold_off_req;

  always #5 clk = ~clk;

  // Offer one frame byte after a random gap and wait until it is taken. The
  // scoreboard is updated at the edge of the transfer. Valid stays high after
  // the transfer so back-to-back bytes need no second assignment in a step.
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_if.valid     <= 1'b1;
    frame_if.in_byte   <= b;
    frame_if.frame_end <= e;
    do @(posedge clk); while (!frame_if.ready);
    book.take_byte(b, e);
    bytes_sent++;
  endtask

  // Register writes only happen with the block drained: every expected
  // result delivered, plus the settling wait for a byte that causes none.
  task automatic write_format(input bit wired);
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= wired;
    @(posedge clk);
    book.set_format(wired);
    cfg_we <= 1'b0;
  endtask

  // One frame of len bytes with random content. The config and prefix bytes
  // are biased toward the crypt modes that carry a block counter and toward
  // the fill pattern, so both the dropped and the kept prefix show up often.
  // With closed cleared the frame never ends; a register write aborts it.
  task automatic send_frame(input int len, input bit closed);
    logic [4:0] mode;
    logic [7:0] mode_byte, pre0, pre1, b;
    int         pick;
    steady_in = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0: mode = MODE_PLAIN;
      1: mode = MODE_CBC;
      2: mode = MODE_CBC_EPH;
      3: mode = MODE_ASYM;
      default: mode = 5'($urandom_range(0, 31));
    endcase
    mode_byte = {3'($urandom_range(0, 7)), mode};
    pick = $urandom_range(0, 9);
    pre0 = 8'($urandom_range(0, 255));
    pre1 = 8'($urandom_range(0, 255));
    if (pick < 4) begin
      pre0 = FILL_BYTE;
      pre1 = FILL_BYTE;
    end else if (pick == 4) begin
      pre0 = FILL_BYTE;
    end else if (pick == 5) begin
      pre1 = FILL_BYTE;
    end
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 11) b = mode_byte;
      if (i == 12) b = pre0;
      if (i == 13) b = pre1;
      send_byte(b, closed && (i == len - 1));
    end
  endtask

  // Receiver: a random stall before each result, with stretches of no stall
  // at all. On request it holds ready low for a long stretch so the command
  // queue fills and the block pushes back on the frame channel.
  initial begin
    int stall;
    bit steady_out;
    steady_out = 1'b0;
    result_if.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) steady_out = !steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    meter_result_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got.kind          = kind_t'(result_if.kind);
      got.meter_id      = result_if.meter_id;
      got.access_number = result_if.access_number;
      got.meter_status  = result_if.meter_status;
      got.crypt_mode    = result_if.crypt_mode;
      got.block_count   = result_if.block_count;
      got.out_byte      = result_if.out_byte;
      got.last          = result_if.last;
      book.check_result(got);
    end
  end

  // Hard limit on the run, several times the slowest legal run.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0] demo_wireless [15];
    int         random_end, frames, len, hdr_pos, r;
    bit         pressure_done;

    book          = new();
    bytes_sent    = 0;
    steady_in     = 1'b0;
    hold_off_req  = 1'b0;
    pressure_done = 1'b0;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 1'b0;
    frame_if.valid     <= 1'b0;
    frame_if.in_byte   <= '0;
    frame_if.frame_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The block comes out of reset in the wireless format.
    // A frame that ends on its first byte is a short frame.
    send_byte(8'h00, 1'b1);

    // Shortest wireless frame that still carries a header: asymmetric crypt
    // mode with extra bits above the mode field, and the fill prefix that is
    // dropped. The header and the final byte are the only results.
    demo_wireless = '{8'h78, 8'h56, 8'h34, 8'h12, 8'h93, 8'h15, 8'h3C, 8'h07,
                      8'h00, 8'hFF, 8'hA5, 8'hED, FILL_BYTE, FILL_BYTE, 8'h80};
    for (int i = 0; i < 15; i++) send_byte(demo_wireless[i], i == 14);

    // Wired format, shortest frame with a header and every bit set. The
    // header is the final result of the frame, so it carries last.
    write_format(1'b1);
    for (int i = 0; i < 12; i++) send_byte(8'hFF, i == 11);

    // Random part: phases of frames in one format, separated by register
    // writes. Most frames are long enough for a header; the rest end exactly
    // at the length boundary or well before it. A phase may end in the
    // middle of a frame, which the register write then aborts.
    random_end = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_end) begin
      write_format(($urandom_range(0, 3) == 0) ? book.wired_mode : !book.wired_mode);
      frames = $urandom_range(3, 8);
      for (int f = 0; f < frames && bytes_sent < random_end; f++) begin
        hdr_pos = book.wired_mode ? int'(WIRED_HDR_POS) : int'(WIRELESS_HDR_POS);
        r = $urandom_range(0, 99);
        if (r < 5) begin
          len = hdr_pos + 1 + $urandom_range(8, 20);
        end else if (r < 70) begin
          len = hdr_pos + 1 + $urandom_range(0, 8);
        end else if (r < 85) begin
          len = hdr_pos + $urandom_range(0, 1);
        end else begin
          len = $urandom_range(1, hdr_pos);
        end
        send_frame(len, 1'b1);
      end
      // Once in the run, the receiver stops for a long stretch while a long
      // frame is offered, so the queue fills and frame ready drops.
      if (!pressure_done && bytes_sent > random_end - RANDOM_BYTES / 2) begin
        pressure_done = 1'b1;
        hold_off_req  = 1'b1;
        send_frame(40, 1'b1);
      end
      if ($urandom_range(0, 2) == 0) send_frame($urandom_range(1, 20), 1'b0);
    end

    // Drain: all expected results must arrive, then nothing else may.
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
